>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop on every rising clock edge outside reset.
`define KPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop on every rising clock edge, reset included.
`define KPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KPC_ASSERT(label, clk, rst, prop, msg)
`define KPC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/kpc_pkg.sv
// Types, constants and helper functions of the keypad PIN collector.
package kpc_pkg;

   localparam int unsigned MAX_DIGITS_DEF = 16;
   localparam int unsigned KEY_W          = 4;

   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [3:0]  END_KEY_RESET = 4'd11;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
   localparam logic [5:0]  FRAME_BITS    = 6'd8;
   localparam logic [5:0]  TICK_BITS     = 6'd0;
   localparam logic [3:0]  KEY_ALIAS     = 4'h1;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_END_KEY = 1'b1;

   typedef logic [4:0]       len_type;
   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   typedef struct packed {
      logic    ready_res;
      len_type pin_length;
      key_type key_code;
      logic    key_seen;
      logic    frame_error;
      logic    overflow;
      key_type digit;
      logic    digit_valid;
      logic    last;
   } rsp_type;

   // Key is the inverted top nibble; codes 12 to 15 alias to key 1.
   function automatic key_type decode_key(input logic [7:0] frame);
      key_type k;
      k = ~frame[7:4];
      if (k[3:2] == 2'b11) begin
         k = KEY_ALIAS;
      end
      return k;
   endfunction

endpackage

>>> rtl/kpc_if.sv
// Request and response channel interfaces of the keypad PIN collector.
interface kpc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [5:0] bit_count;
   logic [7:0] frame_byte;

   modport source (output valid, output op, output bit_count, output frame_byte,
                   input ready);
   modport sink   (input valid, input op, input bit_count, input frame_byte,
                   output ready);
endinterface

interface kpc_rsp_if;
   logic       valid;
   logic       ready;
   logic       ready_res;
   logic [4:0] pin_length;
   logic [3:0] key_code;
   logic       key_seen;
   logic       frame_error;
   logic       overflow;
   logic [3:0] digit;
   logic       digit_valid;
   logic       last;

   modport source (output valid, output ready_res, output pin_length, output key_code,
                   output key_seen, output frame_error, output overflow, output digit,
                   output digit_valid, output last, input ready);
   modport sink   (input valid, input ready_res, input pin_length, input key_code,
                   input key_seen, input frame_error, input overflow, input digit,
                   input digit_valid, input last, output ready);
endinterface

>>> rtl/keypad_pin_collector_unit.sv
// Top level of the keypad PIN collector: sequencer, state registers, result register.
//
//   channel   dir   handshake        payload
//   req_chan  in    valid / ready    op, bit_count, frame_byte
//   rsp_chan  out   valid / ready    ready_res .. last (one or more per request)
//   csr_*     in    csr_we           csr_index, csr_wdata
//
// A poll or frame request is accepted, then completed in one execute step.
// A take request is accepted and executed, then each stored digit is read from memory and sent,
// as the digit memory has a single read port and the incrementer is shared.
// Reset is synchronous; it clears counters and flags, the digit memory is not cleared.
// The execute and send steps stall while the result register still holds an untaken result.
`include "assert_macros.svh"

module keypad_pin_collector_unit #(
   parameter int unsigned MAX_DIGITS = kpc_pkg::MAX_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   kpc_req_if.sink          req_chan,
   kpc_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);

   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type MAX_CNT = cnt_type'(MAX_DIGITS);

   kpc_pkg::state_type state_ff, state_in;

   logic [15:0]      timeout_ff, timeout_in;
   kpc_pkg::key_type end_key_ff, end_key_in;
   logic [15:0]      idle_ff, idle_in;
   cnt_type          count_ff, count_in;
   logic             ready_ff, ready_in;
   cnt_type          idx_ff, idx_in;

   logic             op_ff;
   logic [5:0]       bits_ff;
   logic [7:0]       byte_ff;

   kpc_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;
   logic             slot_free;

   logic [15:0]      inc_a;
   logic [15:0]      inc_sum;
   logic [15:0]      idle_next;
   kpc_pkg::key_type key;
   logic             req_fire;

   logic             mem_we;
   logic             mem_re;
   kpc_pkg::key_type mem_rdata;

   logic             take_done;

   kpc_digit_store #(
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (key),
      .rd_en   (mem_re),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready = (state_ff == kpc_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign key            = kpc_pkg::decode_key(byte_ff);

   // Shared incrementer: idle ticks, digit count or take index.
   always_comb begin
      inc_a = 16'(count_ff);
      unique case (state_ff)
         kpc_pkg::ST_EXEC: begin
            if (bits_ff == kpc_pkg::TICK_BITS) begin
               inc_a = idle_ff;
            end
         end
         kpc_pkg::ST_SEND: inc_a = 16'(idx_ff);
         default: inc_a = 16'(count_ff);
      endcase
   end

   assign inc_sum   = inc_a + 16'd1;
   assign idle_next = (idle_ff == kpc_pkg::IDLE_MAX) ? idle_ff : inc_sum;

   always_comb begin
      state_in   = state_ff;
      timeout_in = timeout_ff;
      end_key_in = end_key_ff;
      idle_in    = idle_ff;
      count_in   = count_ff;
      ready_in   = ready_ff;
      idx_in     = idx_ff;
      rsp_in     = rsp_ff;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            kpc_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            kpc_pkg::CSR_END_KEY: end_key_in = csr_wdata[3:0];
         endcase
      end

      unique case (state_ff)
         kpc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = kpc_pkg::ST_EXEC;
            end
         end
         kpc_pkg::ST_EXEC: begin
            if (slot_free) begin
               rsp_in             = '0;
               rsp_in.last        = 1'b1;
               state_in           = kpc_pkg::ST_IDLE;
               if (op_ff == kpc_pkg::OP_TAKE) begin
                  idx_in = '0;
                  if (count_ff != '0) begin
                     state_in = kpc_pkg::ST_READ;
                  end else begin
                     ready_in = 1'b0;
                     rsp_load = 1'b1;
                  end
               end else begin
                  rsp_load = 1'b1;
                  if (bits_ff == kpc_pkg::TICK_BITS) begin
                     idle_in = idle_next;
                     if (idle_next > timeout_ff) begin
                        ready_in = (count_ff != '0);
                     end
                  end else if (bits_ff != kpc_pkg::FRAME_BITS) begin
                     rsp_in.frame_error = 1'b1;
                     count_in           = '0;
                     ready_in           = 1'b0;
                  end else begin
                     idle_in         = '0;
                     rsp_in.key_code = key;
                     rsp_in.key_seen = 1'b1;
                     if (key == end_key_ff) begin
                        ready_in = (count_ff != '0);
                     end else if (count_ff != MAX_CNT) begin
                        mem_we   = 1'b1;
                        count_in = inc_sum[CNT_W-1:0];
                     end else begin
                        rsp_in.overflow = 1'b1;
                     end
                  end
                  rsp_in.ready_res  = ready_in;
                  rsp_in.pin_length = kpc_pkg::len_type'(count_in);
               end
            end
         end
         kpc_pkg::ST_READ: begin
            mem_re   = 1'b1;
            state_in = kpc_pkg::ST_SEND;
         end
         kpc_pkg::ST_SEND: begin
            if (slot_free) begin
               rsp_load           = 1'b1;
               rsp_in             = '0;
               rsp_in.digit       = mem_rdata;
               rsp_in.digit_valid = 1'b1;
               rsp_in.last        = (inc_sum[CNT_W-1:0] == count_ff);
               idx_in             = inc_sum[CNT_W-1:0];
               if (rsp_in.last) begin
                  count_in = '0;
                  ready_in = 1'b0;
                  state_in = kpc_pkg::ST_IDLE;
               end else begin
                  state_in = kpc_pkg::ST_READ;
               end
            end
         end
         default: state_in = kpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpc_pkg::ST_IDLE;
         timeout_ff   <= kpc_pkg::TIMEOUT_RESET;
         end_key_ff   <= kpc_pkg::END_KEY_RESET;
         idle_ff      <= '0;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         end_key_ff   <= end_key_in;
         idle_ff      <= idle_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload and register the next response.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_chan.op;
         bits_ff <= req_chan.bit_count;
         byte_ff <= req_chan.frame_byte;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ready_res   = rsp_ff.ready_res;
   assign rsp_chan.pin_length  = rsp_ff.pin_length;
   assign rsp_chan.key_code    = rsp_ff.key_code;
   assign rsp_chan.key_seen    = rsp_ff.key_seen;
   assign rsp_chan.frame_error = rsp_ff.frame_error;
   assign rsp_chan.overflow    = rsp_ff.overflow;
   assign rsp_chan.digit       = rsp_ff.digit;
   assign rsp_chan.digit_valid = rsp_ff.digit_valid;
   assign rsp_chan.last        = rsp_ff.last;

   assign take_done = rsp_load && rsp_in.digit_valid && rsp_in.last;

   `KPC_ASSERT(a_count_bound, clock, reset, count_ff <= MAX_CNT, "digit count beyond depth")
   `KPC_ASSERT(a_ready_needs_digits, clock, reset, ready_ff |-> (count_ff != '0), "no digits")
   `KPC_ASSERT(a_write_in_range, clock, reset, mem_we |-> (count_ff != MAX_CNT), "write past store")
   `KPC_ASSERT(a_take_clears, clock, reset, take_done |=> (!ready_ff && count_ff == '0), "PIN kept")
   `KPC_ASSERT(a_busy_after_accept, clock, reset, req_fire |=> !req_chan.ready, "accepted while busy")

endmodule

>>> rtl/kpc_digit_store.sv
// PIN digit memory: one write port, one read port with registered data.
module kpc_digit_store #(
   parameter  int unsigned DEPTH  = kpc_pkg::MAX_DIGITS_DEF,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  kpc_pkg::key_type      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output kpc_pkg::key_type      rd_data
);

   kpc_pkg::key_type mem [DEPTH];
   kpc_pkg::key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> verif/keypad_pin_collector_unit_test.sv
// Testbench for the keypad PIN collector: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module keypad_pin_collector_unit_test;

   localparam int PIN_DEPTH       = kpc_pkg::MAX_DIGITS_DEF;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int MAX_ERROR_LINES = 30;
   localparam int IDLE_RUN        = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = kpc_pkg::CSR_TIMEOUT;
   logic [15:0] csr_wdata = '0;

   kpc_req_if req_chan ();
   kpc_rsp_if rsp_chan ();

   keypad_pin_collector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow state of the collector
   kpc_pkg::key_type pin_store [PIN_DEPTH];
   int               pin_count;
   logic [15:0]      idle_count;
   logic             pin_ready;
   logic [15:0]      timeout_reg;
   kpc_pkg::key_type end_key_reg;

   kpc_pkg::rsp_type pending_pin_rsp [$];

   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_cycles;
   int cycle_count;
   int mismatch_count;
   int req_count;
   int take_count;
   int bad_frame_count;
   int dropped_key_count;
   int rsp_count;
   int setting_count;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still awaited",
                  cycle_count, pending_pin_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_ERROR_LINES)
         $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want, input int idx);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got %0d, want %0d", idx, name, got, want));
   endtask

   always @(posedge clock) begin : rsp_check
      kpc_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pin_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_count));
         end else begin
            want = pending_pin_rsp.pop_front();
            check_field("ready_res", 32'(rsp_chan.ready_res), 32'(want.ready_res), rsp_count);
            check_field("pin_length", 32'(rsp_chan.pin_length), 32'(want.pin_length),
                        rsp_count);
            check_field("key_code", 32'(rsp_chan.key_code), 32'(want.key_code), rsp_count);
            check_field("key_seen", 32'(rsp_chan.key_seen), 32'(want.key_seen), rsp_count);
            check_field("frame_error", 32'(rsp_chan.frame_error), 32'(want.frame_error),
                        rsp_count);
            check_field("overflow", 32'(rsp_chan.overflow), 32'(want.overflow), rsp_count);
            check_field("digit", 32'(rsp_chan.digit), 32'(want.digit), rsp_count);
            check_field("digit_valid", 32'(rsp_chan.digit_valid), 32'(want.digit_valid),
                        rsp_count);
            check_field("last", 32'(rsp_chan.last), 32'(want.last), rsp_count);
         end
         rsp_count++;
      end
   end

   function automatic kpc_pkg::key_type key_of_frame(input logic [7:0] frame);
      kpc_pkg::key_type key;
      key = ~frame[7:4];
      if (key >= 4'd12)
         key = kpc_pkg::KEY_ALIAS;
      return key;
   endfunction

   // Pick a frame byte that decodes to the given key, aliases included
   function automatic logic [7:0] frame_of_key(input kpc_pkg::key_type key);
      logic [3:0] top;
      top = ~key;
      if (key == kpc_pkg::KEY_ALIAS && $urandom_range(1))
         top = 4'($urandom_range(3));
      return {top, 4'($urandom_range(15))};
   endfunction

   // Advance the shadow state by one request and queue the results it causes
   function automatic void pin_collector_step(input logic op, input logic [5:0] bits,
                                              input logic [7:0] frame);
      kpc_pkg::rsp_type r;
      kpc_pkg::key_type key;
      int n;
      r = '0;
      r.last = 1'b1;
      if (op == kpc_pkg::OP_TAKE) begin
         n = pin_count;
         pin_count = 0;
         pin_ready = 1'b0;
         take_count++;
         if (n == 0)
            pending_pin_rsp.push_back(r);
         for (int i = 0; i < n; i++) begin
            r.digit       = pin_store[i];
            r.digit_valid = 1'b1;
            r.last        = (i == n - 1);
            pending_pin_rsp.push_back(r);
         end
         return;
      end
      if (bits == kpc_pkg::TICK_BITS) begin
         if (idle_count != kpc_pkg::IDLE_MAX)
            idle_count++;
         if (idle_count > timeout_reg)
            pin_ready = (pin_count != 0);
      end else if (bits != kpc_pkg::FRAME_BITS) begin
         r.frame_error = 1'b1;
         pin_count = 0;
         pin_ready = 1'b0;
         bad_frame_count++;
      end else begin
         idle_count = '0;
         key = key_of_frame(frame);
         r.key_code = key;
         r.key_seen = 1'b1;
         if (key == end_key_reg) begin
            pin_ready = (pin_count != 0);
         end else if (pin_count < PIN_DEPTH) begin
            pin_store[pin_count] = key;
            pin_count++;
         end else begin
            r.overflow = 1'b1;
            dropped_key_count++;
         end
      end
      r.ready_res  = pin_ready;
      r.pin_length = kpc_pkg::len_type'(pin_count);
      pending_pin_rsp.push_back(r);
   endfunction

   // Offer one request; valid stays high afterwards until the next request or a settle
   task automatic send_req(input logic op, input logic [5:0] bits, input logic [7:0] frame);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.bit_count  <= bits;
      req_chan.frame_byte <= frame;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pin_collector_step(op, bits, frame);
      req_count++;
   endtask

   task automatic send_key(input kpc_pkg::key_type key);
      send_req(kpc_pkg::OP_POLL, kpc_pkg::FRAME_BITS, frame_of_key(key));
   endtask

   task automatic send_tick();
      send_req(kpc_pkg::OP_POLL, kpc_pkg::TICK_BITS, 8'($urandom_range(255)));
   endtask

   task automatic send_take();
      send_req(kpc_pkg::OP_TAKE, 6'($urandom_range(63)), 8'($urandom_range(255)));
   endtask

   // Drop valid, drain all results, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_pin_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] timeout, input kpc_pkg::key_type end_key);
      settle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= kpc_pkg::CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(negedge clock);
      csr_index <= kpc_pkg::CSR_END_KEY;
      csr_wdata <= {12'h000, end_key};
      @(negedge clock);
      csr_we <= 1'b0;
      timeout_reg = timeout;
      end_key_reg = end_key;
      setting_count++;
   endtask

   // Every top nibble, store full, overflow, take full and empty store
   task automatic test_key_decoding();
      for (int nib = 0; nib < 16; nib++)
         send_req(kpc_pkg::OP_POLL, kpc_pkg::FRAME_BITS, {4'(nib), (nib % 2) ? 4'hF : 4'h0});
      send_key(4'd0);
      send_key(4'd5);
      send_key(end_key_reg);
      send_take();
      send_take();
      send_key(end_key_reg);
      send_req(kpc_pkg::OP_TAKE, 6'd63, 8'hFF);
   endtask

   task automatic test_bad_frames();
      send_key(4'd9);
      send_req(kpc_pkg::OP_POLL, 6'd63, 8'h00);
      send_key(4'd10);
      send_req(kpc_pkg::OP_POLL, 6'd1, 8'hFF);
      send_key(4'd3);
      send_req(kpc_pkg::OP_POLL, 6'd9, 8'h5A);
      send_req(kpc_pkg::OP_POLL, 6'd7, 8'hA5);
      send_req(kpc_pkg::OP_POLL, 6'd32, 8'h00);
      send_take();
   endtask

   task automatic test_timeout();
      write_regs(16'd0, 4'd10);
      send_tick();
      send_key(4'd3);
      send_tick();
      send_key(4'd10);
      send_req(kpc_pkg::OP_POLL, 6'd16, 8'h00);
      send_take();
      write_regs(16'd3, kpc_pkg::KEY_ALIAS);
      send_req(kpc_pkg::OP_POLL, kpc_pkg::FRAME_BITS, 8'h2C);
      send_key(4'd2);
      repeat (5) send_tick();
      send_key(4'd8);
      send_req(kpc_pkg::OP_POLL, kpc_pkg::FRAME_BITS, 8'hE0);
      send_take();
   endtask

   // The largest timeout stays quiet; a lower one fires once the count passes it
   task automatic test_idle_limit();
      write_regs(16'hFFFF, kpc_pkg::END_KEY_RESET);
      send_key(4'd7);
      repeat (IDLE_RUN) send_tick();
      write_regs(16'(IDLE_RUN), kpc_pkg::END_KEY_RESET);
      send_tick();
      send_take();
   endtask

   // Hold the response side off while requests keep coming, so the block backs up
   task automatic test_backpressure();
      settle();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 30; i++) begin
         if (i % 10 == 9)
            send_take();
         else
            send_key(4'($urandom_range(11)));
      end
   endtask

   task automatic test_random_traffic(input int count);
      int stop_at;
      int n;
      kpc_pkg::key_type key;
      stop_at = req_count + count;
      while (req_count < stop_at) begin
         if ($urandom_range(99) < 70) begin
            // Well-formed entry: digits, then a closing step or none, usually a take
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, PIN_DEPTH + 2);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(99) < 15)
                  send_tick();
               do key = 4'($urandom_range(11)); while (key == end_key_reg);
               send_key(key);
            end
            case ($urandom_range(2))
               0: send_key(end_key_reg);
               1: if (timeout_reg <= 16'd10) repeat (int'(timeout_reg) + 1) send_tick();
               default: ;
            endcase
            if ($urandom_range(99) < 80)
               send_take();
         end else begin
            case ($urandom_range(3))
               0: send_req(kpc_pkg::OP_POLL, 6'($urandom_range(63)), 8'($urandom_range(255)));
               1: send_req(kpc_pkg::OP_POLL, kpc_pkg::FRAME_BITS, 8'($urandom_range(255)));
               2: send_tick();
               default: send_req(1'($urandom_range(1)), 6'($urandom_range(63)),
                                 8'($urandom_range(255)));
            endcase
         end
      end
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.op         = kpc_pkg::OP_POLL;
      req_chan.bit_count  = '0;
      req_chan.frame_byte = '0;
      timeout_reg = kpc_pkg::TIMEOUT_RESET;
      end_key_reg = kpc_pkg::END_KEY_RESET;
      pin_count   = 0;
      idle_count  = '0;
      pin_ready   = 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 82;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_key_decoding();
      test_bad_frames();
      test_timeout();
      write_regs(16'd3, 4'd10);
      test_random_traffic(125);

      send_idle_pct = 82;
      recv_idle_pct = 37;
      test_backpressure();
      write_regs(16'd0, 4'd0);
      test_random_traffic(125);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_idle_limit();
      write_regs(16'($urandom_range(8)), 4'($urandom_range(11)));
      test_random_traffic(125);

      settle();
      $display("Covered %0d requests (%0d takes, %0d bad frames, %0d dropped keys), %0d results",
               req_count, take_count, bad_frame_count, dropped_key_count, rsp_count);
      $display("across %0d register settings, idle timeout limits and a long hold-off",
               setting_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/kpc_pkg.sv
rtl/kpc_if.sv
rtl/kpc_digit_store.sv
rtl/keypad_pin_collector_unit.sv
verif/keypad_pin_collector_unit_test.sv
